// File: hdl/lrpa_pkg.sv
// lrpa_pkg: shared constants, types and codes of the length/residue profile algebra unit
// no dependencies; used by the interfaces, the concat unit and the top level

package lrpa_pkg;

	localparam int MAX_MOD = 10;
	localparam int SLOT_W  = 3;
	localparam int MASK_W  = 30;
	localparam int RES_W   = 10;
	localparam int MOD_W   = 4;
	localparam int OP_W    = 3;
	localparam int CNT_W   = 32;
	localparam int SPAN_W  = $clog2(3 * MAX_MOD + 1);

	localparam logic [MOD_W-1:0]  MOD_MIN   = MOD_W'(2);
	localparam logic [MOD_W-1:0]  MOD_MAX   = MOD_W'(MAX_MOD);
	localparam logic [MOD_W-1:0]  MOD_RESET = MOD_W'(2);
	localparam logic [MASK_W-1:0] UNIT_MASK = MASK_W'(1);
	localparam logic [MASK_W-1:0] CHR_SIGMA = MASK_W'(1) << (1 * SLOT_W + 1);
	localparam logic [MASK_W-1:0] CHR_OTHER = MASK_W'(1) << 1;

	localparam logic [OP_W-1:0] OP_CAT   = OP_W'(0);
	localparam logic [OP_W-1:0] OP_POW   = OP_W'(1);
	localparam logic [OP_W-1:0] OP_STAR  = OP_W'(2);
	localparam logic [OP_W-1:0] OP_LOOP  = OP_W'(3);
	localparam logic [OP_W-1:0] OP_CHARS = OP_W'(4);

	typedef struct packed {
		logic              start;
		logic [MASK_W-1:0] x;
		logic [MASK_W-1:0] y;
	} cat_req_t;

	typedef struct packed {
		logic              done;
		logic [MASK_W-1:0] result;
	} cat_rsp_t;

endpackage

// File: hdl/lrpa_cmd_if.sv
// lrpa_cmd_if: valid/ready channel carrying one operation item
// depends on lrpa_pkg for field widths

interface lrpa_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [lrpa_pkg::OP_W-1:0]   op;
	logic [lrpa_pkg::MASK_W-1:0] mask_a;
	logic [lrpa_pkg::MASK_W-1:0] mask_b;
	logic [lrpa_pkg::CNT_W-1:0]  count_lo;
	logic [lrpa_pkg::CNT_W-1:0]  count_hi;
	logic                       cls_sym;
	logic                       cls_other;

	modport source(output valid, op, mask_a, mask_b, count_lo, count_hi, cls_sym, cls_other,
		input ready);
	modport sink(input valid, op, mask_a, mask_b, count_lo, count_hi, cls_sym, cls_other,
		output ready);
endinterface

// File: hdl/lrpa_rsp_if.sv
// lrpa_rsp_if: valid/ready channel carrying one result item
// depends on lrpa_pkg for field widths

interface lrpa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [lrpa_pkg::MASK_W-1:0] result_mask;
	logic [lrpa_pkg::RES_W-1:0]  residues;

	modport source(output valid, result_mask, residues, input ready);
	modport sink(input valid, result_mask, residues, output ready);
endinterface

// File: hdl/lrpa_cat_unit.sv
// lrpa_cat_unit: shared concat unit, one residue slot of x per cycle against a rotating y
// depends on lrpa_pkg

module lrpa_cat_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [lrpa_pkg::MOD_W-1:0]      modulus,
	input  lrpa_pkg::cat_req_t              req,
	output lrpa_pkg::cat_rsp_t              rsp
);

	logic [lrpa_pkg::MASK_W-1:0] xs_q;
	logic [lrpa_pkg::MASK_W-1:0] rb_q;
	logic [lrpa_pkg::MASK_W-1:0] acc_q;
	logic [lrpa_pkg::MOD_W-1:0]  cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [lrpa_pkg::MASK_W-1:0] rb_rot;
	logic [lrpa_pkg::MASK_W-1:0] contrib;
	logic [lrpa_pkg::SLOT_W-1:0] last_slot;
	logic [lrpa_pkg::SLOT_W-1:0] t;
	logic [lrpa_pkg::MOD_W-1:0]  mod_last;

	assign mod_last = modulus - lrpa_pkg::MOD_W'(1);

	// rotate y by one slot within the modulus
	always_comb begin
		last_slot = '0;
		for (int c = 0; c < lrpa_pkg::MAX_MOD; c++) begin
			if (lrpa_pkg::MOD_W'(c) == mod_last) begin
				last_slot = rb_q[c*lrpa_pkg::SLOT_W +: lrpa_pkg::SLOT_W];
			end
		end
		rb_rot = '0;
		for (int c = 0; c < lrpa_pkg::MAX_MOD; c++) begin
			if (c == 0) begin
				rb_rot[0 +: lrpa_pkg::SLOT_W] = last_slot;
			end else if (lrpa_pkg::MOD_W'(c) < modulus) begin
				rb_rot[c*lrpa_pkg::SLOT_W +: lrpa_pkg::SLOT_W] =
					rb_q[(c-1)*lrpa_pkg::SLOT_W +: lrpa_pkg::SLOT_W];
			end
		end
	end

	// saturating length add of the current x slot against every y slot
	always_comb begin
		contrib = '0;
		t = '0;
		for (int c = 0; c < lrpa_pkg::MAX_MOD; c++) begin
			t = rb_q[c*lrpa_pkg::SLOT_W +: lrpa_pkg::SLOT_W];
			contrib[c*lrpa_pkg::SLOT_W +: lrpa_pkg::SLOT_W] =
				({lrpa_pkg::SLOT_W{xs_q[0]}} & t) |
				({lrpa_pkg::SLOT_W{xs_q[1]}} & {t[1] | t[2], t[0], 1'b0}) |
				({lrpa_pkg::SLOT_W{xs_q[2]}} & {|t, 2'b00});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			xs_q   <= req.x;
			rb_q   <= req.y;
			acc_q  <= '0;
			cnt_q  <= modulus;
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			acc_q <= acc_q | contrib;
			xs_q  <= xs_q >> lrpa_pkg::SLOT_W;
			rb_q  <= rb_rot;
			cnt_q <= cnt_q - lrpa_pkg::MOD_W'(1);
			if (cnt_q == lrpa_pkg::MOD_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

endmodule

// File: hdl/length_residue_profile_algebra_unit.sv
// length_residue_profile_algebra_unit: top level, operation sequencer around the concat unit
// depends on lrpa_pkg, lrpa_cmd_if, lrpa_rsp_if and lrpa_cat_unit
//
// Usage: one item on cmd names an operation on profile masks (concat, power, star,
// bounded loop, single chars); one item comes back on rsp with the result mask and
// its residue set. The user must write the modulus register (cfg_we/cfg_wdata) only while
// the block is idle; the block does not enforce it. Values below 2 act as 2, above 10 as 10.
// cmd.ready is high only while the sequencer is idle, so one item is worked at a time.
// Every concat product runs on the single shared concat unit; m below is the
// effective modulus. Concat products per item:
//   single chars or unused op: none
//   concat: one
//   power with exponent n: up to 2*bits(n) products
//   star: one product per fixpoint round, at most about 3*m rounds
//   bounded loop: power of the lower bound, then up to 3*m + 1 more products
// The result sits in an output register; the next item can be taken while it waits
// on a stalled receiver, and a second result waits in the sequencer until rsp frees.
// Reset clears the sequencer, the output valid and sets the modulus to 2.

module length_residue_profile_algebra_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lrpa_pkg::MOD_W-1:0]  cfg_wdata,
	lrpa_cmd_if.sink                    cmd,
	lrpa_rsp_if.source                  rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_CAT, S_PW_CHK, S_PW_MUL, S_PW_SHIFT, S_PW_SQ, S_POST_PW,
		S_ST_WAIT, S_LP_FIN, S_EN, S_EN_WAIT, S_DONE
	} state_t;

	state_t                        state_q;
	logic [lrpa_pkg::MOD_W-1:0]    modulus_q;
	logic [lrpa_pkg::MOD_W-1:0]    m_q;
	logic [lrpa_pkg::OP_W-1:0]     op_q;
	logic [lrpa_pkg::MASK_W-1:0]   a_q;
	logic [lrpa_pkg::MASK_W-1:0]   r_q;
	logic [lrpa_pkg::MASK_W-1:0]   base_q;
	logic [lrpa_pkg::MASK_W-1:0]   s_q;
	logic [lrpa_pkg::MASK_W-1:0]   res_q;
	logic [lrpa_pkg::CNT_W-1:0]    e_q;
	logic [lrpa_pkg::CNT_W-1:0]    span_q;
	logic [lrpa_pkg::SPAN_W-1:0]   cnt_q;
	logic                          ov_q;
	logic [lrpa_pkg::MASK_W-1:0]   omask_q;
	logic [lrpa_pkg::RES_W-1:0]    ores_q;
	lrpa_pkg::cat_req_t            cat_req_q;
	lrpa_pkg::cat_rsp_t            cat_rsp;

	logic [lrpa_pkg::MOD_W-1:0]    m_eff;
	logic [lrpa_pkg::MASK_W-1:0]   vmask;
	logic [lrpa_pkg::MASK_W-1:0]   in_a;
	logic [lrpa_pkg::MASK_W-1:0]   in_b;
	logic [lrpa_pkg::MASK_W-1:0]   chars_mask;
	logic [lrpa_pkg::SPAN_W-1:0]   m3;
	logic [lrpa_pkg::MASK_W-1:0]   s_next;
	logic [lrpa_pkg::RES_W-1:0]    res_set;

	always_comb begin
		m_eff = modulus_q;
		if (modulus_q < lrpa_pkg::MOD_MIN) begin
			m_eff = lrpa_pkg::MOD_MIN;
		end else if (modulus_q > lrpa_pkg::MOD_MAX) begin
			m_eff = lrpa_pkg::MOD_MAX;
		end
	end

	always_comb begin
		vmask = '0;
		for (int c = 0; c < lrpa_pkg::MAX_MOD; c++) begin
			if (lrpa_pkg::MOD_W'(c) < m_eff) begin
				vmask[c*lrpa_pkg::SLOT_W +: lrpa_pkg::SLOT_W] = '1;
			end
		end
	end

	always_comb begin
		res_set = '0;
		for (int c = 0; c < lrpa_pkg::RES_W; c++) begin
			res_set[c] = |res_q[c*lrpa_pkg::SLOT_W +: lrpa_pkg::SLOT_W];
		end
	end

	assign in_a   = cmd.mask_a & vmask;
	assign in_b   = cmd.mask_b & vmask;
	assign chars_mask = (cmd.cls_sym ? lrpa_pkg::CHR_SIGMA : '0) |
		(cmd.cls_other ? lrpa_pkg::CHR_OTHER : '0);
	assign m3     = {m_q, 1'b0} + lrpa_pkg::SPAN_W'(m_q);
	assign s_next = s_q | cat_rsp.result;

	assign cmd.ready       = (state_q == S_IDLE);
	assign rsp.valid       = ov_q;
	assign rsp.result_mask = omask_q;
	assign rsp.residues    = ores_q;

	lrpa_cat_unit u_cat (
		.clk     (clk),
		.arst_n  (arst_n),
		.modulus (m_q),
		.req     (cat_req_q),
		.rsp     (cat_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			modulus_q       <= lrpa_pkg::MOD_RESET;
			m_q             <= lrpa_pkg::MOD_RESET;
			cat_req_q.start <= 1'b0;
			ov_q            <= 1'b0;
		end else begin
			if (cat_req_q.start) begin
				cat_req_q.start <= 1'b0;
			end
			if (cfg_we) begin
				modulus_q <= cfg_wdata;
			end
			if (ov_q && rsp.ready && state_q != S_DONE) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						m_q    <= m_eff;
						op_q   <= cmd.op;
						a_q    <= in_a;
						e_q    <= cmd.count_lo;
						span_q <= cmd.count_hi - cmd.count_lo;
						case (cmd.op) inside
							lrpa_pkg::OP_CAT: begin
								cat_req_q <= '{start: 1'b1, x: in_a, y: in_b};
								state_q   <= S_CAT;
							end
							lrpa_pkg::OP_POW, lrpa_pkg::OP_LOOP: begin
								if (cmd.op == lrpa_pkg::OP_LOOP &&
									cmd.count_lo > cmd.count_hi) begin
									res_q   <= '0;
									state_q <= S_DONE;
								end else begin
									r_q     <= lrpa_pkg::UNIT_MASK;
									base_q  <= in_a;
									state_q <= S_PW_CHK;
								end
							end
							lrpa_pkg::OP_STAR: begin
								s_q       <= lrpa_pkg::UNIT_MASK;
								cat_req_q <= '{start: 1'b1, x: lrpa_pkg::UNIT_MASK, y: in_a};
								state_q   <= S_ST_WAIT;
							end
							lrpa_pkg::OP_CHARS: begin
								res_q   <= chars_mask;
								state_q <= S_DONE;
							end
							default: begin
								res_q   <= '0;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_CAT: begin
					if (cat_rsp.done) begin
						res_q   <= cat_rsp.result;
						state_q <= S_DONE;
					end
				end
				S_PW_CHK: begin
					if (e_q == '0) begin
						state_q <= S_POST_PW;
					end else if (e_q[0]) begin
						cat_req_q <= '{start: 1'b1, x: r_q, y: base_q};
						state_q   <= S_PW_MUL;
					end else begin
						state_q <= S_PW_SHIFT;
					end
				end
				S_PW_MUL: begin
					if (cat_rsp.done) begin
						r_q     <= cat_rsp.result;
						state_q <= S_PW_SHIFT;
					end
				end
				S_PW_SHIFT: begin
					e_q <= e_q >> 1;
					if (e_q[lrpa_pkg::CNT_W-1:1] != '0) begin
						cat_req_q <= '{start: 1'b1, x: base_q, y: base_q};
						state_q   <= S_PW_SQ;
					end else begin
						state_q <= S_PW_CHK;
					end
				end
				S_PW_SQ: begin
					if (cat_rsp.done) begin
						base_q  <= cat_rsp.result;
						state_q <= S_PW_CHK;
					end
				end
				S_POST_PW: begin
					if (op_q == lrpa_pkg::OP_POW) begin
						res_q   <= r_q;
						state_q <= S_DONE;
					end else if (span_q > lrpa_pkg::CNT_W'(m3)) begin
						s_q       <= lrpa_pkg::UNIT_MASK;
						cat_req_q <= '{start: 1'b1, x: lrpa_pkg::UNIT_MASK, y: a_q};
						state_q   <= S_ST_WAIT;
					end else begin
						s_q     <= '0;
						base_q  <= r_q;
						cnt_q   <= span_q[lrpa_pkg::SPAN_W-1:0];
						state_q <= S_EN;
					end
				end
				S_ST_WAIT: begin
					if (cat_rsp.done) begin
						if (s_next == s_q) begin
							if (op_q == lrpa_pkg::OP_STAR) begin
								res_q   <= s_q;
								state_q <= S_DONE;
							end else begin
								cat_req_q <= '{start: 1'b1, x: r_q, y: s_q};
								state_q   <= S_LP_FIN;
							end
						end else begin
							s_q       <= s_next;
							cat_req_q <= '{start: 1'b1, x: s_next, y: a_q};
						end
					end
				end
				S_LP_FIN: begin
					if (cat_rsp.done) begin
						res_q   <= cat_rsp.result;
						state_q <= S_DONE;
					end
				end
				S_EN: begin
					s_q <= s_q | base_q;
					if (cnt_q == '0) begin
						res_q   <= s_q | base_q;
						state_q <= S_DONE;
					end else begin
						cnt_q     <= cnt_q - lrpa_pkg::SPAN_W'(1);
						cat_req_q <= '{start: 1'b1, x: base_q, y: a_q};
						state_q   <= S_EN_WAIT;
					end
				end
				S_EN_WAIT: begin
					if (cat_rsp.done) begin
						base_q  <= cat_rsp.result;
						state_q <= S_EN;
					end
				end
				S_DONE: begin
					if (!ov_q || rsp.ready) begin
						ov_q    <= 1'b1;
						omask_q <= res_q;
						ores_q  <= res_set;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
